// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- src/mktg_pkg.sv -----
// ----------------------------------------------------------------------------
// mktg_pkg
// Shared constants, types and the quarter-wave sine table of the keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package mktg_pkg;

	localparam int SINE_ROM_ENTRIES = 1024;
	localparam int PHASE_BITS       = 24;
	localparam int ROM_BITS         = $clog2(SINE_ROM_ENTRIES);
	localparam int QTR_ENTRIES      = SINE_ROM_ENTRIES / 4;
	localparam int QTR_BITS         = ROM_BITS - 1;

	localparam int AMPLITUDE  = 32000;
	localparam int MAG_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int SYM_W      = 2;
	localparam int QS_W       = 20;
	localparam int STEP_W     = 23;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;
	localparam int PAT_W      = 4;
	localparam int QL_W       = 3;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE     = 2'd2;

	localparam logic [QS_W-1:0]   RST_QUANTUM_SAMPLES = 20'd2880;
	localparam logic [STEP_W-1:0] RST_PHASE_STEP      = 23'd1398101;

	// symbol codes
	localparam logic [SYM_W-1:0] SYM_NONE  = 2'd0;
	localparam logic [SYM_W-1:0] SYM_DOT   = 2'd1;
	localparam logic [SYM_W-1:0] SYM_DASH  = 2'd2;
	localparam logic [SYM_W-1:0] SYM_SPACE = 2'd3;

	// quantum patterns, current quantum in bit 0, 1 = tone on
	localparam logic [PAT_W-1:0] PAT_DOT   = 4'h1;
	localparam logic [PAT_W-1:0] PAT_DASH  = 4'h7;
	localparam logic [PAT_W-1:0] PAT_SPACE = 4'h0;
	localparam logic [QL_W-1:0]  QL_DOT    = 3'd2;
	localparam logic [QL_W-1:0]  QL_DASH   = 3'd4;
	localparam logic [QL_W-1:0]  QL_SPACE  = 3'd2;

	// one classified tick, front to back
	typedef struct packed {
		logic [ROM_BITS-1:0] idx;
		logic                tone;
		logic                active;
		logic                taken;
	} rec_t;

	typedef logic [MAG_W-1:0] qrom_t [QTR_ENTRIES+1];

	// 32000*sin((pi/2)*m/SINE_ROM_ENTRIES), Q30 Taylor series, rounded
	function automatic logic [MAG_W-1:0] quarter_sine(input int m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] v;
		if (m == 0) begin
			return '0;
		end
		if (m >= SINE_ROM_ENTRIES) begin
			return MAG_W'(AMPLITUDE);
		end
		x    = (HALF_PI_Q30 * 64'(m)) / SINE_ROM_ENTRIES;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - signed'(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + signed'(term);
		term = ((term * x2) >> 30) / 210;
		sum  = sum - signed'(term);
		if (sum < 0) begin
			sum = '0;
		end
		v = (unsigned'(sum) * 64'(AMPLITUDE) + (64'd1 << 29)) >> 30;
		if (v > 64'(AMPLITUDE)) begin
			v = 64'(AMPLITUDE);
		end
		return v[MAG_W-1:0];
	endfunction

	function automatic qrom_t build_qrom();
		qrom_t rom;
		for (int j = 0; j <= QTR_ENTRIES; j++) begin
			rom[j] = quarter_sine(4 * j);
		end
		return rom;
	endfunction

	localparam qrom_t QTR_ROM = build_qrom();

endpackage

`default_nettype wire

// ----- src/mktg_front.sv -----
// ----------------------------------------------------------------------------
// mktg_front
// Accepts sample ticks, runs the symbol pattern and phase state, and
// pushes one classified record per tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mktg_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [mktg_pkg::SYM_W-1:0]    symbol_code,
	input  wire logic [mktg_pkg::QS_W-1:0]     quantum_samples,
	input  wire logic [mktg_pkg::STEP_W-1:0]   phase_step,
	input  wire logic                          q_full,
	output logic                               push,
	output mktg_pkg::rec_t                     rec
);
	import mktg_pkg::*;

	logic [PAT_W-1:0]      pat_q, pat_c;
	logic [QL_W-1:0]       ql_q, ql_c;
	logic [QS_W-1:0]       siq_q, siq_c, siq_inc, limit;
	logic [PHASE_BITS-1:0] ph_q, ph_c, ph_sum;
	logic                  start, active, last, accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		pat_c = pat_q;
		ql_c  = ql_q;
		siq_c = siq_q;
		ph_c  = ph_q;
		start = 1'b0;
		if (ql_q == '0) begin
			case (symbol_code)
				SYM_DOT: begin
					start = 1'b1;
					pat_c = PAT_DOT;
					ql_c  = QL_DOT;
				end
				SYM_DASH: begin
					start = 1'b1;
					pat_c = PAT_DASH;
					ql_c  = QL_DASH;
				end
				SYM_SPACE: begin
					start = 1'b1;
					pat_c = PAT_SPACE;
					ql_c  = QL_SPACE;
				end
				default: start = 1'b0;
			endcase
			if (start) begin
				siq_c = '0;
				ph_c  = '0;
			end
		end
		active  = (ql_c != '0);
		siq_inc = siq_c + QS_W'(1);
		limit   = (quantum_samples == '0) ? QS_W'(1) : quantum_samples;
		last    = (siq_inc == '0) || (siq_inc >= limit);
		ph_sum  = ph_c + PHASE_BITS'(phase_step);
	end

	always_comb begin
		rec.idx    = ph_c[PHASE_BITS-1 -: ROM_BITS];
		rec.tone   = active && pat_c[0];
		rec.active = active;
		rec.taken  = start;
		push       = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			ql_q  <= '0;
			siq_q <= '0;
			ph_q  <= '0;
		end else if (accept && active) begin
			if (last) begin
				// close the quantum: restart phase, drop to the next quantum
				siq_q <= '0;
				ph_q  <= '0;
				pat_q <= pat_c >> 1;
				ql_q  <= ql_c - QL_W'(1);
			end else begin
				siq_q <= siq_inc;
				ph_q  <= ph_sum;
				pat_q <= pat_c;
				ql_q  <= ql_c;
			end
		end
	end

	`ASSERT_ALWAYS(a_idle_clear, clk, arst_n, (ql_q == '0) |-> (pat_q == '0 && siq_q == '0 && ph_q == '0), "idle state not cleared")
	`ASSERT_NEVER(a_ql_bound, clk, arst_n, ql_q > QL_DASH, "quanta count out of range")

endmodule

`default_nettype wire

// ----- src/mktg_queue.sv -----
// ----------------------------------------------------------------------------
// mktg_queue
// Two-entry queue of classified records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mktg_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mktg_pkg::rec_t rec_in,
	output logic               full,
	input  wire logic          pop,
	output mktg_pkg::rec_t     rec_out,
	output logic               not_empty
);
	import mktg_pkg::*;

	rec_t       data_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rec_out   = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= rec_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`ASSERT_NEVER(a_overflow, clk, arst_n, push && full, "push into full queue")
	`ASSERT_NEVER(a_underflow, clk, arst_n, pop && !not_empty, "pop from empty queue")
	`ASSERT_ALWAYS(a_ptr_count, clk, arst_n, (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "pointers disagree with count")

endmodule

`default_nettype wire

// ----- src/mktg_back.sv -----
// ----------------------------------------------------------------------------
// mktg_back
// Looks up the sine sample for each record and holds it in the output
// register until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mktg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          not_empty,
	input  wire mktg_pkg::rec_t                rec,
	output logic                               pop,
	input  wire logic                          stereo_mode,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mktg_pkg::SAMPLE_W-1:0]      sample_left,
	output logic [mktg_pkg::SAMPLE_W-1:0]      sample_right,
	output logic                               sample_valid,
	output logic                               symbol_taken
);
	import mktg_pkg::*;

	logic [1:0]            quad;
	logic [QTR_BITS-1:0]   qidx;
	logic [MAG_W-1:0]      mag;
	logic [SAMPLE_W-1:0]   sample;
	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   left_q, right_q;
	logic                  svalid_q, taken_q;

	always_comb begin
		quad = rec.idx[ROM_BITS-1 -: 2];
		// odd quadrants read the quarter table backwards
		if (quad[0]) begin
			qidx = QTR_BITS'(QTR_ENTRIES) - {1'b0, rec.idx[ROM_BITS-3:0]};
		end else begin
			qidx = {1'b0, rec.idx[ROM_BITS-3:0]};
		end
		mag = QTR_ROM[qidx];
		if (!rec.tone) begin
			sample = '0;
		end else if (quad[1]) begin
			sample = SAMPLE_W'(-signed'({1'b0, mag}));
		end else begin
			sample = {1'b0, mag};
		end
	end

	assign pop = not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			left_q   <= sample;
			right_q  <= stereo_mode ? sample : '0;
			svalid_q <= rec.active;
			taken_q  <= rec.taken;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_left  = left_q;
	assign sample_right = right_q;
	assign sample_valid = svalid_q;
	assign symbol_taken = taken_q;

endmodule

`default_nettype wire

// ----- src/morse_keyed_tone_generator_top.sv -----
// ----------------------------------------------------------------------------
// morse_keyed_tone_generator_top
// Morse keyer producing sine tone samples, one result word per sample tick.
// ----------------------------------------------------------------------------
// Each accepted input word is one audio sample tick and yields exactly one
// result word. The block takes one tick per clock cycle while in_stall is
// low. A tick is written into the two-entry record queue at the edge that
// accepts it; its sine lookup is then loaded into the output register when
// the entry is popped, which waits while a held result word is stalled.
// in_stall rises only when the queue is full; while ticks stream back to
// back one queue entry is occupied, so a single cycle of output stall is
// enough to raise it. Configuration writes take effect at once
// and are meant to be issued while no tick is in flight.
`default_nettype none

module morse_keyed_tone_generator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mktg_pkg::SYM_W-1:0]        symbol_code,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mktg_pkg::SAMPLE_W-1:0]          sample_left,
	output logic [mktg_pkg::SAMPLE_W-1:0]          sample_right,
	output logic                                   sample_valid,
	output logic                                   symbol_taken,
	input  wire logic                              cfg_write,
	input  wire logic [mktg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mktg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mktg_pkg::*;

	logic [QS_W-1:0]   quantum_samples_q;
	logic [STEP_W-1:0] phase_step_q;
	logic              stereo_mode_q;

	rec_t front_rec, back_rec;
	logic push, q_full, pop, q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_samples_q <= RST_QUANTUM_SAMPLES;
			phase_step_q      <= RST_PHASE_STEP;
			stereo_mode_q     <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_QUANTUM_SAMPLES: quantum_samples_q <= cfg_data[QS_W-1:0];
				REG_PHASE_STEP:      phase_step_q      <= cfg_data[STEP_W-1:0];
				REG_STEREO_MODE:     stereo_mode_q     <= cfg_data[0];
				default:             stereo_mode_q     <= stereo_mode_q;
			endcase
		end
	end

	mktg_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.symbol_code     (symbol_code),
		.quantum_samples (quantum_samples_q),
		.phase_step      (phase_step_q),
		.q_full          (q_full),
		.push            (push),
		.rec             (front_rec)
	);

	mktg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec_in    (front_rec),
		.full      (q_full),
		.pop       (pop),
		.rec_out   (back_rec),
		.not_empty (q_not_empty)
	);

	mktg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (q_not_empty),
		.rec          (back_rec),
		.pop          (pop),
		.stereo_mode  (stereo_mode_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.sample_valid (sample_valid),
		.symbol_taken (symbol_taken)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Morse keyed tone generator. Every accepted
// tick is run through a cycle-free model of the keyer, and every result word
// is compared field by field against the oldest predicted sample.
// ----------------------------------------------------------------------------

module tb_top;

	import mktg_pkg::*;

	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam int              SHOWN_MISMATCHES = 10;
	localparam int              PHASE_COUNT      = 8;
	localparam int              TICKS_PER_PHASE  = 115;
	localparam logic [STEP_W-1:0] STEP_MAX       = 23'h7FFFFF;
	localparam logic [STEP_W-1:0] STEP_QUARTER   = 23'd4194304;
	localparam logic [QS_W-1:0]   QS_MAX         = 20'hFFFFF;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                valid;
		logic                taken;
	} tone_word_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [SYM_W-1:0]      symbol_code  = '0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [SAMPLE_W-1:0]   sample_left;
	logic [SAMPLE_W-1:0]   sample_right;
	logic                  sample_valid;
	logic                  symbol_taken;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// model state and configuration
	logic [QS_W-1:0]       quantum_len;
	logic [STEP_W-1:0]     phase_inc;
	logic                  stereo_on;
	logic [PAT_W-1:0]      tone_pat;
	logic [QL_W-1:0]       quanta_todo;
	logic [QS_W-1:0]       quantum_tick;
	logic [PHASE_BITS-1:0] phase_acc;

	logic [SAMPLE_W-1:0]   sine_table [SINE_ROM_ENTRIES];
	tone_word_t            pending_samples [$];
	int                    mismatch_count = 0;
	logic                  steady = 1'b0;

	always #2 clk = ~clk;

	morse_keyed_tone_generator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.symbol_code  (symbol_code),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.sample_valid (sample_valid),
		.symbol_taken (symbol_taken),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 32000*sin((pi/2)*m/SINE_ROM_ENTRIES), Q30 Taylor series to x^15
	function automatic int quarter_wave(input int m);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		if (m == 0) begin
			return 0;
		end
		if (m >= SINE_ROM_ENTRIES) begin
			return AMPLITUDE;
		end
		x    = (QUARTER_TURN_Q30 * longint'(m)) / SINE_ROM_ENTRIES;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (longint'(sum) * AMPLITUDE + (64'd1 << 29)) >> 30;
		if (v > AMPLITUDE) begin
			v = AMPLITUDE;
		end
		return int'(v);
	endfunction

	function automatic void fill_sine_table();
		int r;
		int mag;
		for (int k = 0; k < SINE_ROM_ENTRIES; k++) begin
			r   = (4 * k) % SINE_ROM_ENTRIES;
			mag = (((4 * k) / SINE_ROM_ENTRIES) % 2 == 1) ?
				quarter_wave(SINE_ROM_ENTRIES - r) : quarter_wave(r);
			sine_table[k] = ((4 * k) / SINE_ROM_ENTRIES >= 2) ?
				SAMPLE_W'(-mag) : SAMPLE_W'(mag);
		end
	endfunction

	// one tick of the keyer; queue the sample it produces
	function automatic void advance_keyer(input logic [SYM_W-1:0] sym);
		tone_word_t       w;
		logic [QS_W-1:0]  span;
		w = '0;
		if (quanta_todo == 0 && sym != SYM_NONE) begin
			case (sym)
				SYM_DOT: begin
					tone_pat    = PAT_DOT;
					quanta_todo = QL_DOT;
				end
				SYM_DASH: begin
					tone_pat    = PAT_DASH;
					quanta_todo = QL_DASH;
				end
				default: begin
					tone_pat    = PAT_SPACE;
					quanta_todo = QL_SPACE;
				end
			endcase
			quantum_tick = '0;
			phase_acc    = '0;
			w.taken      = 1'b1;
		end
		if (quanta_todo != 0) begin
			w.valid = 1'b1;
			if (tone_pat[0]) begin
				w.left = sine_table[phase_acc[PHASE_BITS-1 -: ROM_BITS]];
			end
			phase_acc    = phase_acc + PHASE_BITS'(phase_inc);
			quantum_tick = quantum_tick + QS_W'(1);
			span         = (quantum_len == 0) ? QS_W'(1) : quantum_len;
			// close the quantum on wrap or once the count reaches the length
			if (quantum_tick == 0 || quantum_tick >= span) begin
				quantum_tick = '0;
				phase_acc    = '0;
				tone_pat     = tone_pat >> 1;
				quanta_todo  = quanta_todo - QL_W'(1);
			end
		end
		w.right = stereo_on ? w.left : '0;
		pending_samples.push_back(w);
	endfunction

	task automatic flag(input string what, input logic [SAMPLE_W-1:0] want,
			input logic [SAMPLE_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES) begin
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	// result side: random stall, compare every accepted word
	always @(posedge clk) begin
		tone_word_t want;
		out_stall <= !steady && ($urandom_range(99) < 14);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				flag("unexpected word", '0, sample_left);
			end else begin
				want = pending_samples.pop_front();
				if (sample_left !== want.left) flag("sample_left", want.left, sample_left);
				if (sample_right !== want.right) flag("sample_right", want.right, sample_right);
				if (sample_valid !== want.valid) flag("sample_valid", want.valid, sample_valid);
				if (symbol_taken !== want.taken) flag("symbol_taken", want.taken, symbol_taken);
			end
		end
	end

	task automatic send_tick(input logic [SYM_W-1:0] sym);
		while (!steady && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		symbol_code <= sym;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		advance_keyer(sym);
	endtask

	// hold the input side until every predicted sample is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_QUANTUM_SAMPLES: quantum_len = val[QS_W-1:0];
			REG_PHASE_STEP:      phase_inc   = val[STEP_W-1:0];
			REG_STEREO_MODE:     stereo_on   = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [QS_W-1:0] qlen, input logic [STEP_W-1:0] step,
			input logic stereo);
		set_reg(REG_QUANTUM_SAMPLES, {3'($urandom), qlen});
		set_reg(REG_PHASE_STEP, step);
		set_reg(REG_STEREO_MODE, {22'($urandom), stereo});
	endtask

	// default settings: idle ticks, a dot, offers ignored while busy, then a
	// quantum length dropped below the ticks already spent
	task automatic test_idle_and_busy();
		send_tick(SYM_NONE);
		send_tick(SYM_NONE);
		send_tick(SYM_DOT);
		send_tick(SYM_DASH);
		send_tick(SYM_SPACE);
		send_tick(SYM_NONE);
		drain();
		set_reg(REG_QUANTUM_SAMPLES, CFG_DATA_W'(1));
		repeat (3) send_tick(SYM_NONE);
		drain();
	endtask

	// quarter-turn step hits the positive and negative peaks in stereo
	task automatic test_sine_peaks();
		configure(20'd4, STEP_QUARTER, 1'b1);
		send_tick(SYM_DOT);
		repeat (6) send_tick(SYM_SPACE);
		drain();
	endtask

	// zero length acts as one tick per quantum, mono, full step
	task automatic test_zero_quantum();
		configure('0, STEP_MAX, 1'b0);
		send_tick(SYM_DASH);
		repeat (3) send_tick(SYM_DOT);
		send_tick(SYM_SPACE);
		send_tick(SYM_DOT);
		drain();
	endtask

	// longest quantum with the largest step wraps the phase
	task automatic test_phase_wrap();
		configure(QS_MAX, STEP_MAX, 1'b1);
		send_tick(SYM_DASH);
		send_tick(SYM_DOT);
		send_tick(SYM_NONE);
		send_tick(SYM_SPACE);
		drain();
	endtask

	task automatic test_random_ticks();
		logic [QS_W-1:0]   qlen;
		logic [STEP_W-1:0] step;
		logic [SYM_W-1:0]  sym;
		int                pick;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			pick = $urandom_range(9);
			qlen = (pick < 7) ? QS_W'($urandom_range(1, 6)) :
				(pick == 7) ? '0 :
				(pick == 8) ? QS_W'($urandom_range(7, 40)) : QS_W'($urandom_range(1, QS_MAX));
			if (p == 0) begin
				qlen = QS_W'($urandom_range(1, 6));
			end
			pick = $urandom_range(4);
			step = (p == 0 || pick == 0) ? '0 :
				(p == 1 || pick == 1) ? STEP_MAX :
				(pick == 2) ? STEP_QUARTER : STEP_W'($urandom_range(0, STEP_MAX));
			configure(qlen, step, 1'($urandom));
			steady = (p == 3);
			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				// mostly offer a symbol as soon as the keyer goes idle
				if (quanta_todo == 0) begin
					sym = ($urandom_range(99) < 80) ? SYM_W'($urandom_range(1, 3)) : SYM_NONE;
				end else begin
					sym = SYM_W'($urandom_range(0, 3));
				end
				send_tick(sym);
				if (p == 5 && i == TICKS_PER_PHASE / 2) begin
					drain();
				end
			end
			drain();
			steady = 1'b0;
		end
	endtask

	initial begin
		quantum_len  = RST_QUANTUM_SAMPLES;
		phase_inc    = RST_PHASE_STEP;
		stereo_on    = 1'b0;
		tone_pat     = '0;
		quanta_todo  = '0;
		quantum_tick = '0;
		phase_acc    = '0;
		fill_sine_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_and_busy();
		test_sine_peaks();
		test_zero_quantum();
		test_phase_wrap();
		test_random_ticks();
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_samples.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/mktg_pkg.sv
src/mktg_front.sv
src/mktg_queue.sv
src/mktg_back.sv
src/morse_keyed_tone_generator_top.sv
tb/sv/tb_top.sv
